// ===== rtl/core/multi_deque_with_merge_defines.svh =====
// assertion macros for the rtl files, included by mdqm_back
`ifndef MULTI_DEQUE_WITH_MERGE_DEFINES_SVH
`define MULTI_DEQUE_WITH_MERGE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDQM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MDQM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mdqm_pkg.sv =====
`default_nettype none
package mdqm_pkg;

    // sizing, capacity must be a power of two
    localparam int NUM_LISTS = 8;
    localparam int CAPACITY  = 64;
    localparam int LIST_W    = 3;
    localparam int POS_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DEPTH     = NUM_LISTS * CAPACITY;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int DATA_W    = 32;

    typedef logic [LIST_W-1:0] t_list;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_MERGE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // classified command between front and back
    typedef struct packed {
        t_op         op;
        t_list       target;
        t_list       source;
        logic        at_back;
        logic [31:0] value;
        logic        t_ok;
        logic        s_ok;
        logic        self_merge;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POPW,
        S_MLOOK,
        S_MCHK,
        S_MREAD,
        S_MWRITE,
        S_DONE
    } t_state;

    // ring position plus offset, wraps at capacity
    function automatic t_pos ring_add(input t_pos base, input t_cnt off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-POS_W){1'b0}}, base} + {1'b0, off};
        return sum[POS_W-1:0];
    endfunction

    // store address of a ring slot of a list
    function automatic t_addr make_addr(input t_list lst, input t_pos pos);
        logic [ADDR_W+LIST_W-1:0] base;
        base = (ADDR_W+LIST_W)'(lst) * (ADDR_W+LIST_W)'(CAPACITY);
        return base[ADDR_W-1:0] + ADDR_W'(pos);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mdqm_front.sv =====
`default_nettype none
module mdqm_front
    import mdqm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    output t_cmd             o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       in_cmd;
    logic       push;

    // classify the incoming transaction
    always_comb begin
        in_cmd            = '0;
        in_cmd.op         = t_op'(s_axis_tuser);
        in_cmd.target     = s_axis_tdata[2:0];
        in_cmd.source     = s_axis_tdata[5:3];
        in_cmd.at_back    = s_axis_tdata[6];
        in_cmd.value      = s_axis_tdata[38:7];
        in_cmd.t_ok       = 32'(in_cmd.target) < NUM_LISTS;
        in_cmd.s_ok       = 32'(in_cmd.source) < NUM_LISTS;
        in_cmd.self_merge = in_cmd.target == in_cmd.source;
    end

    assign s_axis_tready = r_cnt != 2'd2;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = r_cnt != 2'd0;
    assign o_cmd         = r_q[r_rp];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mdqm_back.sv =====
`default_nettype none
`include "multi_deque_with_merge_defines.svh"
module mdqm_back
    import mdqm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_data,
    output logic [1:0]       o_status
);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_pos   r_ht, n_ht, r_hs, n_hs;
    t_cnt   r_ct, n_ct, r_cs, n_cs, r_k, n_k;
    logic [31:0] r_res_data, n_res_data;
    logic [1:0]  r_res_status, n_res_status;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic [1:0]  r_out_status, n_out_status;

    // list bookkeeping and entry store
    t_pos        r_head  [NUM_LISTS];
    t_cnt        r_count [NUM_LISTS];
    logic [31:0] mem     [DEPTH];
    logic [31:0] r_rd_data;

    t_list       rd_idx;
    t_pos        rd_head;
    t_cnt        rd_count;
    logic        mem_we, mem_re;
    t_addr       mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;
    logic        ma_we_h, ma_we_c, mb_we;
    t_list       ma_idx;
    t_pos        ma_head;
    t_cnt        ma_count;
    logic [CNT_W:0] merge_sum;

    assign rd_idx    = (r_state == S_IDLE) ? i_cmd.target : r_cmd.source;
    assign rd_head   = r_head[rd_idx];
    assign rd_count  = r_count[rd_idx];
    assign merge_sum = {1'b0, r_ct} + {1'b0, r_cs};

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_ht         = r_ht;
        n_ct         = r_ct;
        n_hs         = r_hs;
        n_cs         = r_cs;
        n_k          = r_k;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        o_cmd_pop    = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = '0;
        mem_raddr    = '0;
        mem_wdata    = r_cmd.value;
        ma_we_h      = 1'b0;
        ma_we_c      = 1'b0;
        mb_we        = 1'b0;
        ma_idx       = r_cmd.target;
        ma_head      = r_ht;
        ma_count     = r_ct;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_cmd        = i_cmd;
                    n_ht         = i_cmd.t_ok ? rd_head : '0;
                    n_ct         = i_cmd.t_ok ? rd_count : '0;
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    n_k          = '0;
                    n_state      = (i_cmd.op == OP_MERGE) ? S_MLOOK : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd.op)
                    OP_PUSH: begin
                        if (!r_cmd.t_ok || 32'(r_ct) >= CAPACITY) begin
                            n_res_status = ST_FULL;
                        end else begin
                            mem_we   = 1'b1;
                            ma_we_c  = 1'b1;
                            ma_count = r_ct + t_cnt'(1);
                            if (r_cmd.at_back) begin
                                mem_waddr = make_addr(r_cmd.target, ring_add(r_ht, r_ct));
                            end else begin
                                ma_we_h   = 1'b1;
                                ma_head   = r_ht - t_pos'(1);
                                mem_waddr = make_addr(r_cmd.target, r_ht - t_pos'(1));
                            end
                        end
                    end
                    OP_POP: begin
                        if (!r_cmd.t_ok || r_ct == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            mem_re   = 1'b1;
                            ma_we_c  = 1'b1;
                            ma_count = r_ct - t_cnt'(1);
                            n_state  = S_POPW;
                            if (r_cmd.at_back) begin
                                mem_raddr = make_addr(r_cmd.target,
                                                      ring_add(r_ht, r_ct - t_cnt'(1)));
                            end else begin
                                ma_we_h   = 1'b1;
                                ma_head   = r_ht + t_pos'(1);
                                mem_raddr = make_addr(r_cmd.target, r_ht);
                            end
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_POPW: begin
                n_res_data = r_rd_data;
                n_state    = S_DONE;
            end
            S_MLOOK: begin
                n_hs    = r_cmd.s_ok ? rd_head : '0;
                n_cs    = r_cmd.s_ok ? rd_count : '0;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                n_state = S_DONE;
                if (!r_cmd.s_ok || r_cmd.self_merge || r_cs == '0) begin
                    n_res_status = ST_OK;
                end else if (!r_cmd.t_ok || 32'(merge_sum) > CAPACITY) begin
                    n_res_status = ST_FULL;
                end else begin
                    n_state = S_MREAD;
                end
            end
            S_MREAD: begin
                mem_re = 1'b1;
                if (r_cmd.at_back) begin
                    mem_raddr = make_addr(r_cmd.source,
                                          ring_add(r_hs, r_cs - t_cnt'(1) - r_k));
                end else begin
                    mem_raddr = make_addr(r_cmd.source, ring_add(r_hs, r_k));
                end
                n_state = S_MWRITE;
            end
            S_MWRITE: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                mem_waddr = make_addr(r_cmd.target, ring_add(r_ht, r_ct + r_k));
                n_k       = r_k + t_cnt'(1);
                n_state   = S_MREAD;
                if (r_k == r_cs - t_cnt'(1)) begin
                    ma_we_c  = 1'b1;
                    ma_count = merge_sum[CNT_W-1:0];
                    mb_we    = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ht         <= n_ht;
        r_ct         <= n_ct;
        r_hs         <= n_hs;
        r_cs         <= n_cs;
        r_k          <= n_k;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // head and count per list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (ma_we_h) begin
                r_head[ma_idx] <= ma_head;
            end
            if (ma_we_c) begin
                r_count[ma_idx] <= ma_count;
            end
            if (mb_we) begin
                r_head[r_cmd.source]  <= '0;
                r_count[r_cmd.source] <= '0;
            end
        end
    end

    // entry store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_status = r_out_status;

    `MDQM_ASSERT_IMP(a_copy_in_range, r_state == S_MWRITE, r_k < r_cs,
        "merge copy index beyond source length")
    `MDQM_ASSERT_IMP(a_fail_zero_data, r_out_valid && r_out_status != ST_OK,
        r_out_data == '0, "failed result carries data")
    `MDQM_ASSERT_NXT(a_pop_only_idle, o_cmd_pop, r_state != S_IDLE,
        "command taken but back stayed idle")

endmodule
`default_nettype wire

// ===== rtl/core/multi_deque_with_merge.sv =====
`default_nettype none
// Eight double-ended lists of up to 64 entries each, sharing one 512-entry store.
// A transaction asks for push, pop or merge (tuser); each yields exactly one result
// transaction carrying the popped value and a status (ok, empty, full). A front
// queue of two commands takes input while the back works, so input stalls only
// when that queue is full. The back handles one command at a time; a merge copies
// the source entries one by one, a store read and then a store write per copied
// entry, and the back also waits while the output side is not ready.
module multi_deque_with_merge
    import mdqm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // target_list[2:0], source_list[5:3], at_back[6], push_value[38:7], zero[39]
    input  wire logic [39:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pop_value[31:0]
    output logic [31:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    mdqm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop)
    );

    mdqm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule
`default_nettype wire
